/* src/pmct_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmct_pkg
// Shared types, constants and decode helpers for the PS/2 cursor tracker.
// ----------------------------------------------------------------------------
package pmct_pkg;

  localparam int BYTE_W    = 8;
  localparam int POS_W     = 12;
  localparam int SIZE_W    = 13;
  localparam int CFG_IDX_W = 2;
  localparam int DELTA_W   = 10;
  localparam int SUM_W     = 14;

  // Bit positions within packet byte 0
  localparam int BTN_LEFT_BIT   = 0;
  localparam int BTN_MIDDLE_BIT = 1;
  localparam int BTN_RIGHT_BIT  = 2;
  localparam int SYNC_BIT       = 3;
  localparam int X_SIGN_BIT     = 4;
  localparam int Y_SIGN_BIT     = 5;
  localparam int X_OVF_BIT      = 6;
  localparam int Y_OVF_BIT      = 7;

  localparam logic signed [DELTA_W-1:0] OVF_EXTRA = 10'sd255;
  localparam logic [SIZE_W-1:0] X_MARGIN     = 13'd8;
  localparam logic [SIZE_W-1:0] Y_MARGIN     = 13'd16;
  localparam logic [SIZE_W-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [SIZE_W-1:0] HEIGHT_RESET = 13'd480;
  localparam logic [POS_W-1:0]  POS_RESET    = 12'd10;
  localparam logic [POS_W-1:0]  POS_MAX      = 12'hFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCREEN_WIDTH  = 2'd0,
    CFG_SCREEN_HEIGHT = 2'd1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PH_STATUS = 2'd0,
    PH_XDELTA = 2'd1,
    PH_YDELTA = 2'd2
  } phase_t;

  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data;
  } rx_word_t;

  typedef struct packed {
    logic [POS_W-1:0] cursor_x;
    logic [POS_W-1:0] cursor_y;
    logic             left_pressed;
    logic             middle_pressed;
    logic             right_pressed;
  } result_t;

  typedef struct packed {
    logic    load;
    result_t result;
  } result_word_t;

  // 9-bit two's complement delta, extended by 255 toward the sign on overflow
  function automatic logic signed [DELTA_W-1:0] decode_delta(
      input logic [BYTE_W-1:0] b, input logic neg, input logic ovf);
    logic signed [DELTA_W-1:0] d;
    d = $signed({neg, neg, b});
    if (ovf) begin
      d = neg ? (d - OVF_EXTRA) : (d + OVF_EXTRA);
    end
    return d;
  endfunction

  // size - margin, floored at 0 and saturated to the position range
  function automatic logic [POS_W-1:0] upper_limit(
      input logic [SIZE_W-1:0] size, input logic [SIZE_W-1:0] margin);
    logic [SIZE_W-1:0] diff;
    diff = size - margin;
    if (size < margin) begin
      return '0;
    end else if (diff[SIZE_W-1]) begin
      return POS_MAX;
    end
    return diff[POS_W-1:0];
  endfunction

  function automatic logic [POS_W-1:0] clamp_pos(
      input logic signed [SUM_W-1:0] p, input logic [POS_W-1:0] lim);
    if (p < 0) begin
      return '0;
    end else if (p > $signed({2'b00, lim})) begin
      return lim;
    end
    return p[POS_W-1:0];
  endfunction

endpackage

/* src/pmct_cfg_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmct_cfg_regs
// Screen size registers, written through the plain configuration port.
// ----------------------------------------------------------------------------
module pmct_cfg_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [pmct_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pmct_pkg::SIZE_W-1:0]     cfg_data,
  output logic [pmct_pkg::SIZE_W-1:0]     screen_width,
  output logic [pmct_pkg::SIZE_W-1:0]     screen_height
);
  import pmct_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= WIDTH_RESET;
      screen_height <= HEIGHT_RESET;
    end else if (cfg_write) begin
      // unknown indexes fall through and change nothing
      if (cfg_index == CFG_SCREEN_WIDTH) begin
        screen_width <= cfg_data;
      end
      if (cfg_index == CFG_SCREEN_HEIGHT) begin
        screen_height <= cfg_data;
      end
    end
  end

endmodule

/* src/pmct_in_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmct_in_stage
// Input register for received bytes; refills in the cycle it drains.
// ----------------------------------------------------------------------------
module pmct_in_stage (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [pmct_pkg::BYTE_W-1:0]  rx_byte,
  input  logic                         advance,
  output pmct_pkg::rx_word_t           word
);
  import pmct_pkg::*;

  logic              held_valid;
  logic              held_valid_next;
  logic [BYTE_W-1:0] held_byte;
  logic              accept;

  assign in_stall = held_valid && !advance;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    held_valid_next = held_valid;
    if (accept) begin
      held_valid_next = 1'b1;
    end else if (advance) begin
      held_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else begin
      held_valid <= held_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_byte <= rx_byte;
    end
  end

  assign word.valid = held_valid;
  assign word.data  = held_byte;

endmodule

/* src/pmct_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmct_core
// Packet framing, delta decode and clamped cursor update.
// ----------------------------------------------------------------------------
module pmct_core (
  input  logic                         clk,
  input  logic                         rst,
  input  pmct_pkg::rx_word_t           word,
  input  logic                         slot_free,
  input  logic [pmct_pkg::SIZE_W-1:0]  screen_width,
  input  logic [pmct_pkg::SIZE_W-1:0]  screen_height,
  output logic                         advance,
  output pmct_pkg::result_word_t       res
);
  import pmct_pkg::*;

  phase_t                    phase;
  phase_t                    phase_next;
  logic [BYTE_W-1:0]         status_byte;
  logic [BYTE_W-1:0]         x_delta_byte;
  logic [POS_W-1:0]          pos_x;
  logic [POS_W-1:0]          pos_y;
  logic [POS_W-1:0]          pos_x_next;
  logic [POS_W-1:0]          pos_y_next;
  logic signed [DELTA_W-1:0] dx;
  logic signed [DELTA_W-1:0] dy;
  logic signed [SUM_W-1:0]   nx;
  logic signed [SUM_W-1:0]   ny;
  logic                      emits;

  // Third byte closes a packet; hold it only when the result slot is busy
  assign advance = word.valid && (!emits || slot_free);

  // Next state
  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_XDELTA: phase_next = PH_YDELTA;
      PH_YDELTA: phase_next = PH_STATUS;
      default:   phase_next = word.data[SYNC_BIT] ? PH_XDELTA : PH_STATUS;
    endcase
  end

  // Outputs
  always_comb begin
    emits = 1'b0;
    unique case (phase)
      PH_YDELTA: emits = 1'b1;
      default:   emits = 1'b0;
    endcase
  end

  always_comb begin
    dx = decode_delta(x_delta_byte, status_byte[X_SIGN_BIT], status_byte[X_OVF_BIT]);
    dy = decode_delta(word.data, status_byte[Y_SIGN_BIT], status_byte[Y_OVF_BIT]);
    nx = $signed({2'b00, pos_x}) + $signed({{(SUM_W-DELTA_W){dx[DELTA_W-1]}}, dx});
    // screen y grows downward
    ny = $signed({2'b00, pos_y}) - $signed({{(SUM_W-DELTA_W){dy[DELTA_W-1]}}, dy});
    pos_x_next = clamp_pos(nx, upper_limit(screen_width, X_MARGIN));
    pos_y_next = clamp_pos(ny, upper_limit(screen_height, Y_MARGIN));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_STATUS;
      status_byte  <= '0;
      x_delta_byte <= '0;
      pos_x        <= POS_RESET;
      pos_y        <= POS_RESET;
    end else if (advance) begin
      phase <= phase_next;
      if (phase == PH_XDELTA) begin
        x_delta_byte <= word.data;
      end else if (phase == PH_YDELTA) begin
        pos_x <= pos_x_next;
        pos_y <= pos_y_next;
      end else if (word.data[SYNC_BIT]) begin
        status_byte <= word.data;
      end
    end
  end

  assign res.load                  = advance && emits;
  assign res.result.cursor_x       = pos_x_next;
  assign res.result.cursor_y       = pos_y_next;
  assign res.result.left_pressed   = status_byte[BTN_LEFT_BIT];
  assign res.result.middle_pressed = status_byte[BTN_MIDDLE_BIT];
  assign res.result.right_pressed  = status_byte[BTN_RIGHT_BIT];

endmodule

/* src/pmct_out_reg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmct_out_reg
// Result register holding one word until the downstream side takes it.
// ----------------------------------------------------------------------------
module pmct_out_reg (
  input  logic                    clk,
  input  logic                    rst,
  input  pmct_pkg::result_word_t  res,
  output logic                    slot_free,
  output logic                    out_valid,
  input  logic                    out_stall,
  output pmct_pkg::result_t       result
);
  import pmct_pkg::*;

  logic    held_valid;
  logic    held_valid_next;
  result_t held;

  assign slot_free = !held_valid || !out_stall;

  always_comb begin
    held_valid_next = held_valid;
    if (res.load) begin
      held_valid_next = 1'b1;
    end else if (!out_stall) begin
      held_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else begin
      held_valid <= held_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (res.load) begin
      held <= res.result;
    end
  end

  assign out_valid = held_valid;
  assign result    = held;

endmodule

/* src/ps2_mouse_cursor_tracker_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2_mouse_cursor_tracker_top
// Frames PS/2 mouse bytes into packets and tracks a clamped cursor position.
// ----------------------------------------------------------------------------
// Output path: a packet's third byte passes the input register, then loads
//   the result register, which raises out_valid and holds it until taken.
// Throughput: one byte per cycle unless a result word is blocked, set by the
//   single input register feeding decode/clamp; three bytes yield one word.
// Reset: synchronous; cursor returns to (10, 10), screen size to 640 x 480,
//   framing waits for a first byte with bit 3 set.
module ps2_mouse_cursor_tracker_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [pmct_pkg::BYTE_W-1:0]     rx_byte,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [pmct_pkg::POS_W-1:0]      cursor_x,
  output logic [pmct_pkg::POS_W-1:0]      cursor_y,
  output logic                            left_pressed,
  output logic                            middle_pressed,
  output logic                            right_pressed,
  input  logic                            cfg_write,
  input  logic [pmct_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pmct_pkg::SIZE_W-1:0]     cfg_data
);
  import pmct_pkg::*;

  logic [SIZE_W-1:0] screen_width;
  logic [SIZE_W-1:0] screen_height;
  rx_word_t          word;
  result_word_t      res;
  result_t           result;
  logic              advance;
  logic              slot_free;

  pmct_cfg_regs u_cfg (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .screen_width  (screen_width),
    .screen_height (screen_height)
  );

  pmct_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .rx_byte  (rx_byte),
    .advance  (advance),
    .word     (word)
  );

  pmct_core u_core (
    .clk           (clk),
    .rst           (rst),
    .word          (word),
    .slot_free     (slot_free),
    .screen_width  (screen_width),
    .screen_height (screen_height),
    .advance       (advance),
    .res           (res)
  );

  pmct_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .res       (res),
    .slot_free (slot_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .result    (result)
  );

  assign cursor_x       = result.cursor_x;
  assign cursor_y       = result.cursor_y;
  assign left_pressed   = result.left_pressed;
  assign middle_pressed = result.middle_pressed;
  assign right_pressed  = result.right_pressed;

endmodule

/* src/pmct_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmct_checker
// Port-level checks on the cursor tracker, bound to the top level.
// ----------------------------------------------------------------------------
module pmct_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [pmct_pkg::POS_W-1:0]  cursor_x,
  input logic [pmct_pkg::POS_W-1:0]  cursor_y
);

  // reset empties the result register
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid set after reset");

  // the input side only backs up behind a blocked result word
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("in_stall without a blocked result");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> ($stable(cursor_x) && $stable(cursor_y)))
    else $error("cursor changed while stalled");

endmodule

bind ps2_mouse_cursor_tracker_top pmct_checker u_pmct_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .cursor_x  (cursor_x),
  .cursor_y  (cursor_y)
);
